// ----- sv/bmrs_pkg.sv -----
// Shared types and constants for the binary map rectangle statistics unit.
// Holds register indexes, category codes and the packed result record.
// No dependencies.
package bmrs_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 7'd64;

	// Internal widths of rectangle sizes and of the area used for ranking.
	localparam int DIM_W  = 7;
	localparam int AREA_W = 2 * DIM_W;

	// Result field widths
	localparam int CATEGORY_W    = 2;
	localparam int LEFT_X_W      = 6;
	localparam int TOP_Y_W       = 6;
	localparam int RECT_WIDTH_W  = 7;
	localparam int RECT_HEIGHT_W = 7;
	localparam int RECT_AREA_W   = 13;

	localparam logic [CATEGORY_W-1:0] CAT_WIDEST  = 2'd0;
	localparam logic [CATEGORY_W-1:0] CAT_TALLEST = 2'd1;
	localparam logic [CATEGORY_W-1:0] CAT_AREA    = 2'd2;

	typedef struct packed {
		logic [CATEGORY_W-1:0]    category;
		logic                     found;
		logic [LEFT_X_W-1:0]      left_x;
		logic [TOP_Y_W-1:0]       top_y;
		logic [RECT_WIDTH_W-1:0]  rect_width;
		logic [RECT_HEIGHT_W-1:0] rect_height;
		logic [RECT_AREA_W-1:0]   rect_area;
		logic                     last;
	} out_rec_t;

endpackage

// ----- sv/binary_map_rectangle_stats_unit.sv -----
// Top level of the binary map rectangle statistics unit.
// Depends on bmrs_pkg (types, codes) and bmrs_ram (column memories).
// Holds the pixel pipeline, the best-rectangle trackers and the result buffer.

// The unit takes a binary map one pixel per item in raster order and, after the
// last pixel of each frame, returns three records: the widest, the tallest and
// the largest-area rectangle, each with its top-left corner, width, height and
// area, or marked not found. A top-left corner is a set pixel whose left and
// upper neighbors are clear or off the map; its width is the run of ones along
// its row and its height the run of ones down its column. Ties go to the corner
// that comes first in raster order. The unit accepts one pixel in every clock
// cycle, except that the last pixel of a frame waits while the previous frame
// end is in flight or its records have not all been taken; pixels of the next
// frame keep flowing meanwhile. The three records reach the result buffer by
// way of fe_s1 and fe_s2 and leave one per cycle while the consumer is ready.
// The map size comes from the num_rows and num_cols registers; a value of zero
// acts as one and a value above the maximum acts as the maximum. A write to
// either register restarts the frame. Any register write must only be made
// while the unit is idle. Per-column state lives in two small RAMs that need
// no clearing pass: each row overwrites its columns before the next reads them.
module binary_map_rectangle_stats_unit #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// Pixel stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [7:0]                           s_axis_tdata,  // [0] pixel, rest zero

	// Result stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [39:0]                          m_axis_tdata,  // found, left_x, top_y,
	                                                            // rect_width, rect_height,
	                                                            // rect_area
	output logic [bmrs_pkg::CATEGORY_W-1:0]      m_axis_tuser,  // category
	output logic                                 m_axis_tlast,

	// Configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bmrs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bmrs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int XW  = $clog2(MAX_COLS);
	localparam int YW  = $clog2(MAX_ROWS);
	localparam int XCW = $clog2(MAX_COLS + 1);
	localparam int YCW = $clog2(MAX_ROWS + 1);
	localparam int YW1 = YW + 1;

	localparam int DIM_W  = bmrs_pkg::DIM_W;
	localparam int AREA_W = bmrs_pkg::AREA_W;

	// Per-column record: pixel of the row above and the open rectangle, if any.
	typedef struct packed {
		logic          above;
		logic          open;
		logic [YW-1:0] top;
	} col_rec_t;

	// A rectangle as candidate or as best of a category.
	typedef struct packed {
		logic              found;
		logic [XW-1:0]     x;
		logic [YW-1:0]     y;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [AREA_W-1:0] area;
	} rect_t;

	function automatic logic [AREA_W-1:0] cat_val(rect_t r, logic [1:0] cat);
		logic [AREA_W-1:0] v;
		case (cat)
			bmrs_pkg::CAT_WIDEST:  v = AREA_W'(r.w);
			bmrs_pkg::CAT_TALLEST: v = AREA_W'(r.h);
			default:               v = r.area;
		endcase
		return v;
	endfunction

	// True when rectangle a ranks above b: larger value, or equal value and
	// a corner earlier in raster order.
	function automatic logic beats(rect_t a, rect_t b, logic [1:0] cat);
		logic [AREA_W-1:0] va;
		logic [AREA_W-1:0] vb;
		logic              earlier;
		va      = cat_val(a, cat);
		vb      = cat_val(b, cat);
		earlier = (a.y < b.y) || ((a.y == b.y) && (a.x < b.x));
		return (va > vb) || ((va == vb) && earlier);
	endfunction

	function automatic bmrs_pkg::out_rec_t to_out(rect_t r, logic [1:0] cat, logic last);
		bmrs_pkg::out_rec_t o;
		o.category    = cat;
		o.found       = r.found;
		o.left_x      = bmrs_pkg::LEFT_X_W'(r.x);
		o.top_y       = bmrs_pkg::TOP_Y_W'(r.y);
		o.rect_width  = bmrs_pkg::RECT_WIDTH_W'(r.w);
		o.rect_height = bmrs_pkg::RECT_HEIGHT_W'(r.h);
		o.rect_area   = bmrs_pkg::RECT_AREA_W'(r.area);
		o.last        = last;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Configuration and map size
	// ------------------------------------------------------------------
	logic [bmrs_pkg::CFG_DATA_W-1:0] num_rows_q;
	logic [bmrs_pkg::CFG_DATA_W-1:0] num_cols_q;
	logic                            cfg_accept;
	logic                            cfg_hit;
	logic [XCW-1:0]                  cols_eff;
	logic [YCW-1:0]                  rows_eff;

	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;

	always_comb begin
		unique case (cfg_index)
			bmrs_pkg::REG_NUM_ROWS: cfg_hit = 1'b1;
			bmrs_pkg::REG_NUM_COLS: cfg_hit = 1'b1;
			default:                cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= bmrs_pkg::SIZE_RESET;
			num_cols_q <= bmrs_pkg::SIZE_RESET;
		end else if (cfg_accept) begin
			unique case (cfg_index)
				bmrs_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data;
				bmrs_pkg::REG_NUM_COLS: num_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_cols_q == '0) begin
			cols_eff = XCW'(1);
		end else if (int'(num_cols_q) > MAX_COLS) begin
			cols_eff = XCW'(MAX_COLS);
		end else begin
			cols_eff = XCW'(num_cols_q);
		end
		if (num_rows_q == '0) begin
			rows_eff = YCW'(1);
		end else if (int'(num_rows_q) > MAX_ROWS) begin
			rows_eff = YCW'(MAX_ROWS);
		end else begin
			rows_eff = YCW'(num_rows_q);
		end
	end

	// A write to a known register restarts the frame.
	logic frame_restart;
	assign frame_restart = cfg_accept && cfg_hit;

	// ------------------------------------------------------------------
	// Input side: raster position and column memory reads
	// ------------------------------------------------------------------
	logic [XW-1:0] pos_x_q;
	logic [YW-1:0] pos_y_q;
	logic          pos_lcol;
	logic          pos_lrow;
	logic          pos_fe;
	logic          in_accept;

	logic          obuf_busy_q;
	logic          fe_s1;
	logic          fe_s2;

	assign pos_lcol = (XCW'(pos_x_q) + XCW'(1)) == cols_eff;
	assign pos_lrow = (YCW'(pos_y_q) + YCW'(1)) == rows_eff;
	assign pos_fe   = pos_lcol && pos_lrow;

	// Only the closing pixel of a frame waits, and only while the result
	// buffer is still draining or another frame end is in flight.
	assign s_axis_tready = !(pos_fe && (obuf_busy_q || fe_s1 || fe_s2));
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else if (frame_restart) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else if (in_accept) begin
			if (pos_lcol) begin
				pos_x_q <= '0;
				pos_y_q <= pos_lrow ? '0 : pos_y_q + YW'(1);
			end else begin
				pos_x_q <= pos_x_q + XW'(1);
			end
		end
	end

	// Column memories: one holds the pixel above and the open rectangle,
	// the other the width of the rectangle whose corner sits in that column.
	col_rec_t         col_wr_data;
	logic             col_wr_en;
	logic [XW-1:0]    col_wr_addr;
	col_rec_t         col_rd_ram;
	logic             wid_wr_en;
	logic [XW-1:0]    wid_wr_addr;
	logic [DIM_W-1:0] wid_wr_data;
	logic [DIM_W-1:0] wid_rd_ram;

	bmrs_ram #(
		.WIDTH ($bits(col_rec_t)),
		.DEPTH (MAX_COLS)
	) u_col_ram (
		.clk     (clk),
		.wr_en   (col_wr_en),
		.wr_addr (col_wr_addr),
		.wr_data (col_wr_data),
		.rd_en   (in_accept),
		.rd_addr (pos_x_q),
		.rd_data (col_rd_ram)
	);

	bmrs_ram #(
		.WIDTH (DIM_W),
		.DEPTH (MAX_COLS)
	) u_wid_ram (
		.clk     (clk),
		.wr_en   (wid_wr_en),
		.wr_addr (wid_wr_addr),
		.wr_data (wid_wr_data),
		.rd_en   (in_accept),
		.rd_addr (pos_x_q),
		.rd_data (wid_rd_ram)
	);

	// ------------------------------------------------------------------
	// Stage 1: pixel classification, run tracking, candidate rectangles
	// ------------------------------------------------------------------
	logic             valid_s1;
	logic             pix_s1;
	logic [XW-1:0]    x_s1;
	logic [YW-1:0]    y_s1;
	logic             lcol_s1;
	logic             lrow_s1;
	logic             fwdc_hit_s1;
	col_rec_t         fwdc_data_s1;
	logic             fwdw_hit_s1;
	logic [DIM_W-1:0] fwdw_data_s1;

	logic             left_q;
	logic             run_act_q;
	logic [XW-1:0]    run_start_q;
	logic [DIM_W-1:0] run_len_q;

	// When the previous pixel writes the very column this pixel reads in the
	// same cycle (one-column maps, or a run ending where the next read lands),
	// the memory returns old data, so the written value is carried along.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fe_s1    <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
			fe_s1    <= in_accept && pos_fe;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1       <= s_axis_tdata[0];
			x_s1         <= pos_x_q;
			y_s1         <= pos_y_q;
			lcol_s1      <= pos_lcol;
			lrow_s1      <= pos_lrow;
			fwdc_hit_s1  <= col_wr_en && (col_wr_addr == pos_x_q);
			fwdc_data_s1 <= col_wr_data;
			fwdw_hit_s1  <= wid_wr_en && (wid_wr_addr == pos_x_q);
			fwdw_data_s1 <= wid_wr_data;
		end
	end

	col_rec_t         col_rd;
	logic [DIM_W-1:0] wid_rd;
	logic             row_gt0;
	logic             up;
	logic             open_eff;
	logic             corner;
	logic             run_end;
	logic [XW-1:0]    end_start;
	logic [DIM_W-1:0] end_len;
	logic             act_n;
	logic [XW-1:0]    start_n;
	logic [DIM_W-1:0] len_n;
	logic [DIM_W-1:0] h_close;
	logic [YW1-1:0]   h_last_full;
	rect_t            cand0;
	rect_t            cand1;

	always_comb begin
		col_rd   = fwdc_hit_s1 ? fwdc_data_s1 : col_rd_ram;
		wid_rd   = fwdw_hit_s1 ? fwdw_data_s1 : wid_rd_ram;
		// On the first row nothing above counts; stale entries from an earlier
		// frame are masked here and overwritten by this row.
		row_gt0  = (y_s1 != '0);
		up       = row_gt0 && col_rd.above;
		open_eff = row_gt0 && col_rd.open;
		corner   = pix_s1 && !left_q && !up;

		// A corner always follows a clear pixel or a row start, so the run
		// has already ended there; only a clear pixel or the row end ends one.
		run_end   = 1'b0;
		end_start = run_start_q;
		end_len   = run_len_q;
		act_n     = run_act_q;
		start_n   = run_start_q;
		len_n     = run_len_q;
		if (!pix_s1) begin
			run_end = run_act_q;
			act_n   = 1'b0;
		end else if (corner) begin
			act_n   = 1'b1;
			start_n = x_s1;
			len_n   = DIM_W'(1);
			if (lcol_s1) begin
				run_end   = 1'b1;
				end_start = x_s1;
				end_len   = DIM_W'(1);
			end
		end else if (run_act_q) begin
			len_n = run_len_q + DIM_W'(1);
			if (lcol_s1) begin
				run_end = 1'b1;
				end_len = run_len_q + DIM_W'(1);
			end
		end
		if (lcol_s1) begin
			act_n = 1'b0;
		end

		col_wr_en         = valid_s1;
		col_wr_addr       = x_s1;
		col_wr_data.above = pix_s1;
		col_wr_data.open  = corner || (pix_s1 && !lrow_s1 && open_eff);
		col_wr_data.top   = corner ? y_s1 : col_rd.top;

		wid_wr_en   = valid_s1 && run_end;
		wid_wr_addr = end_start;
		wid_wr_data = end_len;

		// Candidate from the column: its rectangle closes on a clear pixel,
		// or, on the last row, reaches the bottom edge of the map.
		h_close     = DIM_W'(y_s1 - col_rd.top);
		h_last_full = YW1'(y_s1) + YW1'(1) - YW1'(col_rd.top);
		cand0.found = valid_s1 && open_eff && (!pix_s1 || lrow_s1);
		cand0.x     = x_s1;
		cand0.y     = col_rd.top;
		cand0.w     = wid_rd;
		cand0.h     = pix_s1 ? DIM_W'(h_last_full) : h_close;
		cand0.area  = AREA_W'(cand0.w) * AREA_W'(cand0.h);

		// Candidate from the run: a corner on the last row has height one.
		cand1.found = valid_s1 && run_end && lrow_s1;
		cand1.x     = end_start;
		cand1.y     = y_s1;
		cand1.w     = end_len;
		cand1.h     = DIM_W'(1);
		cand1.area  = AREA_W'(end_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= 1'b0;
			run_act_q   <= 1'b0;
			run_start_q <= '0;
			run_len_q   <= '0;
		end else if (frame_restart) begin
			left_q      <= 1'b0;
			run_act_q   <= 1'b0;
			run_start_q <= '0;
			run_len_q   <= '0;
		end else if (valid_s1) begin
			left_q      <= pix_s1 && !lcol_s1;
			run_act_q   <= act_n;
			run_start_q <= start_n;
			run_len_q   <= len_n;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: best rectangle per category
	// ------------------------------------------------------------------
	rect_t cand_s2 [2];
	rect_t best_q  [3];
	rect_t best_n  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_s2 <= '{default: '0};
			fe_s2   <= 1'b0;
		end else begin
			cand_s2[0] <= cand0;
			cand_s2[1] <= cand1;
			fe_s2      <= fe_s1;
		end
	end

	// The ranking is a strict total order, so the two candidates of one
	// cycle can be folded in either order.
	always_comb begin
		best_n = best_q;
		for (int i = 0; i < 2; i++) begin
			if (cand_s2[i].found) begin
				for (int c = 0; c < 3; c++) begin
					if (!best_n[c].found || beats(cand_s2[i], best_n[c], 2'(c))) begin
						best_n[c] = cand_s2[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '{default: '0};
		end else if (frame_restart || fe_s2) begin
			best_q <= '{default: '0};
		end else begin
			best_q <= best_n;
		end
	end

	// ------------------------------------------------------------------
	// Result buffer: three records per frame, given out while the consumer is ready, one per cycle
	// ------------------------------------------------------------------
	bmrs_pkg::out_rec_t obuf_q [3];
	logic [1:0]         obuf_idx_q;
	bmrs_pkg::out_rec_t obuf_rd;

	always_ff @(posedge clk) begin
		if (fe_s2) begin
			obuf_q[0] <= to_out(best_n[0], bmrs_pkg::CAT_WIDEST,  1'b0);
			obuf_q[1] <= to_out(best_n[1], bmrs_pkg::CAT_TALLEST, 1'b0);
			obuf_q[2] <= to_out(best_n[2], bmrs_pkg::CAT_AREA,    1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_busy_q <= 1'b0;
			obuf_idx_q  <= '0;
		end else if (fe_s2) begin
			obuf_busy_q <= 1'b1;
			obuf_idx_q  <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (obuf_idx_q == bmrs_pkg::CAT_AREA) begin
				obuf_busy_q <= 1'b0;
				obuf_idx_q  <= '0;
			end else begin
				obuf_idx_q <= obuf_idx_q + 2'd1;
			end
		end
	end

	assign obuf_rd       = obuf_q[obuf_idx_q];
	assign m_axis_tvalid = obuf_busy_q;
	assign m_axis_tdata  = {obuf_rd.rect_area, obuf_rd.rect_height, obuf_rd.rect_width,
	                        obuf_rd.top_y, obuf_rd.left_x, obuf_rd.found};
	assign m_axis_tuser  = obuf_rd.category;
	assign m_axis_tlast  = obuf_rd.last;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A frame end must never land on a buffer that still holds records.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		fe_s2 |-> !obuf_busy_q)
		else $error("result buffer overwritten before it drained");

	// At most one frame end travels through the pipeline.
	a_one_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({fe_s1, fe_s2}) <= 1)
		else $error("two frame ends in flight");

	// A frame end starts the three-record burst with the widest record.
	a_burst_start: assert property (@(posedge clk) disable iff (!arst_n)
		fe_s2 |=> (obuf_busy_q && (obuf_idx_q == bmrs_pkg::CAT_WIDEST)))
		else $error("result burst did not start after frame end");

	// An active run never extends past the columns in use.
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_act_q |-> ((int'(run_start_q) + int'(run_len_q)) <= int'(cols_eff)))
		else $error("row run exceeds the map width");

endmodule

// ----- sv/bmrs_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module bmrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for binary_map_rectangle_stats_unit.
// Streams binary maps through the unit and checks its three records per frame.
// Depends on bmrs_pkg and the unit's RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bmrs_pkg::*;

	localparam int MAP_MAX     = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = 8'd0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [39:0]           m_axis_tdata;
	logic [CATEGORY_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Gap limits for each side, changed per phase; zero gives a stretch with no idling.
	int send_gap_max = 0;
	int recv_gap_max = 0;
	// Set by the stimulus to make the consumer hold off for a long stretch.
	int hold_off_cycles = 0;
	int pixels_sent = 0;
	int cycle_count = 0;

	// Map sizes as last written, and the map of the frame being sent.
	logic [CFG_DATA_W-1:0] rows_written = SIZE_RESET;
	logic [CFG_DATA_W-1:0] cols_written = SIZE_RESET;
	bit pixel_map [MAP_MAX][MAP_MAX];

	out_rec_t seen_rec;

	// A size register of zero acts as one, anything above the maximum as the maximum.
	function automatic int size_in_use(logic [CFG_DATA_W-1:0] v);
		if (v == 0)
			return 1;
		return (v > MAP_MAX) ? MAP_MAX : int'(v);
	endfunction

	// Tracks the map scan exactly as the unit should and holds the records
	// still owed for finished frames.
	class rect_scoreboard;
		logic [CFG_DATA_W-1:0] rows_reg, cols_reg;
		int                    row_pos, col_pos;
		bit                    above [MAP_MAX];
		bit                    left_bit;
		bit                    run_on;
		int                    run_start;
		logic [DIM_W-1:0]      run_len;
		bit                    col_open [MAP_MAX];
		logic [TOP_Y_W-1:0]    col_top [MAP_MAX];
		logic [DIM_W-1:0]      col_w [MAP_MAX];
		bit                    best_found [3];
		logic [LEFT_X_W-1:0]   best_x [3];
		logic [TOP_Y_W-1:0]    best_y [3];
		logic [DIM_W-1:0]      best_w [3];
		logic [DIM_W-1:0]      best_h [3];
		out_rec_t              records_due [$];
		int                    mismatches;

		function new();
			rows_reg = SIZE_RESET;
			cols_reg = SIZE_RESET;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			row_pos = 0;
			col_pos = 0;
			left_bit = 0;
			run_on = 0;
			run_start = 0;
			run_len = '0;
			for (int i = 0; i < MAP_MAX; i++) begin
				above[i] = 0;
				col_open[i] = 0;
				col_top[i] = '0;
				col_w[i] = '0;
			end
			for (int c = 0; c < 3; c++) begin
				best_found[c] = 0;
				best_x[c] = '0;
				best_y[c] = '0;
				best_w[c] = '0;
				best_h[c] = '0;
			end
		endfunction

		function logic [AREA_W-1:0] ranking(int c, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
			case (CATEGORY_W'(c))
				CAT_WIDEST:  return AREA_W'(w);
				CAT_TALLEST: return AREA_W'(h);
				default:     return AREA_W'(w) * AREA_W'(h);
			endcase
		endfunction

		// Offers one closed rectangle to all three trackers; on a tie the
		// corner that comes first in raster order stays.
		function void offer(int x, int y, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
			logic [AREA_W-1:0] val, held;
			bit earlier;
			for (int c = 0; c < 3; c++) begin
				val = ranking(c, w, h);
				held = ranking(c, best_w[c], best_h[c]);
				earlier = (y < best_y[c]) || (y == best_y[c] && x < best_x[c]);
				if (!best_found[c] || val > held || (val == held && earlier)) begin
					best_found[c] = 1;
					best_x[c] = x;
					best_y[c] = y;
					best_w[c] = w;
					best_h[c] = h;
				end
			end
		endfunction

		function void close_col(int col, int end_row);
			if (col_open[col]) begin
				offer(col, col_top[col], col_w[col], DIM_W'(end_row - col_top[col]));
				col_open[col] = 0;
			end
		endfunction

		function void end_run();
			if (run_on) begin
				col_w[run_start] = run_len;
				run_on = 0;
			end
		endfunction

		function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_NUM_ROWS)
				rows_reg = data;
			else if (idx == REG_NUM_COLS)
				cols_reg = data;
			else
				return;
			restart();
		endfunction

		function void note_pixel(bit p);
			int rows, cols, x, y;
			bit lft, up;
			out_rec_t r;
			rows = size_in_use(rows_reg);
			cols = size_in_use(cols_reg);
			x = col_pos;
			y = row_pos;
			if (x >= cols || y >= rows) begin
				restart();
				x = 0;
				y = 0;
			end
			lft = (x > 0) ? left_bit : 0;
			up = (y > 0) ? above[x] : 0;

			if (!p) begin
				close_col(x, y);
				end_run();
			end else if (!lft && !up) begin
				// New top-left corner: open its column and start its row run.
				end_run();
				col_open[x] = 1;
				col_top[x] = y;
				col_w[x] = '0;
				run_on = 1;
				run_start = x;
				run_len = 1;
			end else if (run_on) begin
				run_len++;
			end
			above[x] = p;
			left_bit = p;

			if (x + 1 < cols) begin
				col_pos = x + 1;
				return;
			end
			end_run();
			left_bit = 0;
			col_pos = 0;
			if (y + 1 < rows) begin
				row_pos = y + 1;
				return;
			end

			// Last pixel of the frame: close every open column at the bottom edge.
			for (int c = 0; c < cols; c++)
				close_col(c, rows);
			for (int c = 0; c < 3; c++) begin
				r.category = CATEGORY_W'(c);
				r.found = best_found[c];
				r.left_x = best_found[c] ? best_x[c] : '0;
				r.top_y = best_found[c] ? best_y[c] : '0;
				r.rect_width = best_found[c] ? best_w[c] : '0;
				r.rect_height = best_found[c] ? best_h[c] : '0;
				r.rect_area = best_found[c] ?
					RECT_AREA_W'(AREA_W'(best_w[c]) * AREA_W'(best_h[c])) : '0;
				r.last = (c == 2);
				records_due.push_back(r);
			end
			restart();
		endfunction

		task report(string what);
			$display("%0t ns: result item error: %s", $time, what);
			mismatches++;
		endtask

		task check_record(out_rec_t got);
			out_rec_t want;
			if (records_due.size() == 0) begin
				report("result item arrived with no record due");
				return;
			end
			want = records_due.pop_front();
			if (got.category !== want.category)
				report($sformatf("category %0d, expected %0d", got.category, want.category));
			if (got.found !== want.found)
				report($sformatf("found %0d, expected %0d", got.found, want.found));
			if (got.left_x !== want.left_x)
				report($sformatf("left_x %0d, expected %0d", got.left_x, want.left_x));
			if (got.top_y !== want.top_y)
				report($sformatf("top_y %0d, expected %0d", got.top_y, want.top_y));
			if (got.rect_width !== want.rect_width)
				report($sformatf("rect_width %0d, expected %0d",
					got.rect_width, want.rect_width));
			if (got.rect_height !== want.rect_height)
				report($sformatf("rect_height %0d, expected %0d",
					got.rect_height, want.rect_height));
			if (got.rect_area !== want.rect_area)
				report($sformatf("rect_area %0d, expected %0d", got.rect_area, want.rect_area));
			if (got.last !== want.last)
				report($sformatf("last %0d, expected %0d", got.last, want.last));
		endtask

		function int pending();
			return records_due.size();
		endfunction
	endclass

	rect_scoreboard stats = new();

	binary_map_rectangle_stats_unit #(
		.MAX_COLS(MAP_MAX),
		.MAX_ROWS(MAP_MAX)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result monitor. tdata from bit 0 up: found, left_x, top_y, rect_width,
	// rect_height, rect_area; tuser holds the category.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_rec.category = m_axis_tuser;
			seen_rec.found = m_axis_tdata[0];
			seen_rec.left_x = m_axis_tdata[6:1];
			seen_rec.top_y = m_axis_tdata[12:7];
			seen_rec.rect_width = m_axis_tdata[19:13];
			seen_rec.rect_height = m_axis_tdata[26:20];
			seen_rec.rect_area = m_axis_tdata[39:27];
			seen_rec.last = m_axis_tlast;
			stats.check_record(seen_rec);
		end
	end

	// Consumer: draws a stall before each item, and honors a requested
	// long hold-off, counted here in cycles.
	initial begin : consumer
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_off_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			stall = $urandom_range(0, recv_gap_max);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Offers one pixel item after a random gap; tvalid stays high when the gap is zero.
	task send_pixel(bit p);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, p};
		do @(posedge clk); while (!s_axis_tready);
		stats.note_pixel(p);
		pixels_sent++;
	endtask

	// Sends n pixels, bit 0 first.
	task send_bits(logic [15:0] bits, int n);
		for (int i = 0; i < n; i++)
			send_pixel(bits[i]);
	endtask

	// Waits until every owed record has come, then gives the unit time to
	// finish any frame work that produces no record.
	task settle();
		s_axis_tvalid <= 1'b0;
		while (stats.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data, bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		stats.note_write(idx, data);
		if (idx == REG_NUM_ROWS)
			rows_written = data;
		else if (idx == REG_NUM_COLS)
			cols_written = data;
		if (!more)
			cfg_valid <= 1'b0;
	endtask

	task resize(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols);
		settle();
		write_reg(REG_NUM_ROWS, rows, 1'b1);
		write_reg(REG_NUM_COLS, cols, 1'b0);
	endtask

	// Fills the map either with painted rectangles (which overlap now and
	// then) or with noise of a random density.
	task draw_map(int rows, int cols);
		int style, dens, x0, y0, w, h;
		style = $urandom_range(0, 3);
		dens = ($urandom_range(0, 2) == 0) ? 15 : ($urandom_range(0, 1) ? 50 : 85);
		for (int y = 0; y < rows; y++)
			for (int x = 0; x < cols; x++)
				pixel_map[y][x] = (style == 3) ? ($urandom_range(0, 99) < dens) : 1'b0;
		if (style != 3) begin
			repeat ($urandom_range(1, 3)) begin
				x0 = $urandom_range(0, cols - 1);
				y0 = $urandom_range(0, rows - 1);
				w = $urandom_range(1, cols - x0);
				h = $urandom_range(1, rows - y0);
				for (int y = y0; y < y0 + h; y++)
					for (int x = x0; x < x0 + w; x++)
						pixel_map[y][x] = 1'b1;
			end
		end
	endtask

	// Sends the first count pixels of a fresh map at the current size.
	task run_frame(int count);
		int rows, cols;
		rows = size_in_use(rows_written);
		cols = size_in_use(cols_written);
		draw_map(rows, cols);
		for (int i = 0; i < count; i++)
			send_pixel(pixel_map[i / cols][i % cols]);
	endtask

	initial begin : stimulus
		int start, frame_px, nframes;
		bit must_write;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A one-pixel map, clear and then set.
		resize(7'd1, 7'd1);
		send_pixel(1'b0);
		send_pixel(1'b1);
		// Zero sizes act as one.
		resize(7'd0, 7'd0);
		send_pixel(1'b1);
		// Writes to unused register indexes change nothing.
		settle();
		write_reg(2'd2, 7'd127, 1'b1);
		write_reg(2'd3, 7'd0, 1'b0);
		send_pixel(1'b1);
		// Solid 2 by 2 map: one corner covers the whole map.
		send_gap_max = 6;
		recv_gap_max = 6;
		resize(7'd2, 7'd2);
		send_bits(16'h000F, 4);
		// Two corners of equal height: the tie goes to the leftmost one.
		resize(7'd2, 7'd4);
		send_bits(16'b0101_1101, 8);
		// A run that passes under a set pixel, and a corner on the left edge.
		resize(7'd3, 7'd3);
		send_bits(16'b1_1001_1110, 9);

		// Largest sizes: a 64-column map from an oversized value, then a
		// 64-row single column.
		resize(7'd2, 7'd127);
		run_frame(2 * MAP_MAX);
		resize(7'd127, 7'd0);
		run_frame(MAP_MAX);
		resize(7'd64, 7'd1);
		run_frame(MAP_MAX);

		// The consumer holds off while small frames keep coming, so that the
		// result buffer fills and the last pixel of a frame has to wait.
		start = pixels_sent;
		resize(7'd2, 7'd2);
		send_gap_max = 0;
		recv_gap_max = 0;
		hold_off_cycles = HOLD_CYCLES;
		repeat (6)
			run_frame(4);

		// Random part: small maps, sent one to three frames at a time, with
		// occasional frames cut short by a size change.
		must_write = 1;
		while (pixels_sent - start < 260) begin
			send_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 6;
			recv_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 6;
			if (must_write || $urandom_range(0, 3) != 0) begin
				settle();
				case ($urandom_range(0, 3))
					0: write_reg(REG_NUM_ROWS, $urandom_range(0, 8), 1'b0);
					1: write_reg(REG_NUM_COLS, $urandom_range(0, 8), 1'b0);
					default: begin
						write_reg(REG_NUM_ROWS, $urandom_range(1, 8), 1'b1);
						write_reg(REG_NUM_COLS, $urandom_range(1, 8), 1'b0);
					end
				endcase
			end
			must_write = 0;
			frame_px = size_in_use(rows_written) * size_in_use(cols_written);
			nframes = $urandom_range(1, 3);
			repeat (nframes)
				run_frame(frame_px);
			if (frame_px > 1 && $urandom_range(0, 4) == 0) begin
				run_frame($urandom_range(1, frame_px - 1));
				must_write = 1;
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (stats.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
